@@ hw/rtl/sorted_sparse_entry_table_macros.svh @@
// assertion macros for the sorted sparse entry table
`ifndef SORTED_SPARSE_ENTRY_TABLE_MACROS_SVH
`define SORTED_SPARSE_ENTRY_TABLE_MACROS_SVH
`ifndef SYNTH
// plain property, checked at every edge out of reset
`define SSET_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("sset assertion failed");
// antecedent at one edge, consequent at the next
`define SSET_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sset assertion failed");
`else
`define SSET_ASSERT(lbl, prop)
`define SSET_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ hw/rtl/sset_pkg.sv @@
// shared types and constants for the sorted sparse entry table
`default_nettype none

package sset_pkg;

  localparam int CAPACITY_DEFAULT = 256;

  localparam int IDX_W    = 16;
  localparam int VALUE_W  = 64;
  localparam int KEY_W    = 2 * IDX_W;
  localparam int ENTRY_W  = KEY_W + VALUE_W;
  localparam int COUNT_OUT_W = 9;
  localparam int STATUS_W = 3;

  // stream payload widths, padded to whole bytes
  localparam int IN_W  = 104;
  localparam int OUT_W = 80;

  localparam int CFG_INDEX_W = 8;
  localparam logic [CFG_INDEX_W-1:0] REG_ROW_COUNT = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_COL_COUNT = 8'd1;

  localparam logic [IDX_W-1:0] DIM_RESET = 16'hFFFF;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED      = 3'd0,
    ST_REPLACED      = 3'd1,
    ST_REMOVED       = 3'd2,
    ST_ZERO_NOP      = 3'd3,
    ST_OUT_OF_BOUNDS = 3'd4,
    ST_FULL          = 3'd5,
    ST_READ          = 3'd6
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_DECIDE,
    S_DEL_RD,
    S_DEL_WR,
    S_INS_RD,
    S_INS_WR,
    S_FIN
  } state_t;

endpackage

`default_nettype wire

@@ hw/rtl/sorted_sparse_entry_table.sv @@
// sorted sparse entry table: top level with entry memory and sequencer
//
//  channel | dir | handshake                  | payload
//  --------+-----+----------------------------+--------------------------------
//  s_      | in  | s_tvalid / s_tready        | s_tdata: action,row,col,value
//  m_      | out | m_tvalid / m_tready        | m_tdata: status,read_value,count
//  cfg_    | in  | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// one item is worked on at a time through a single-port entry memory and one
// 32-bit key comparator; each scan step and each moved entry is a memory read,
// then a compare or write back; entries scanned plus entries moved are at most
// the entry count plus one for an insert, remove or read; out-of-bounds items
// go straight from the bounds check to the result; the result register frees
// the input side, so the next item is taken while a result still waits on m_tready
// reset clears the entry count and control state and sets the bounds registers to
// all ones; the entry memory itself is not cleared since only entries below the count are read
`default_nettype none
`include "sorted_sparse_entry_table_macros.svh"

module sorted_sparse_entry_table #(
  parameter int CAPACITY = sset_pkg::CAPACITY_DEFAULT
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  // s_tdata from bit 0: action(1), row(16), col(16), value(64), zero pad
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  input  wire logic [sset_pkg::IN_W-1:0]        s_tdata,
  // m_tdata from bit 0: status(3), read_value(64), entry_count(9), zero pad
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic [sset_pkg::OUT_W-1:0]            m_tdata,
  // configuration writes
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [sset_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [sset_pkg::IDX_W-1:0]       cfg_data
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int IW = sset_pkg::IDX_W;
  localparam int VW = sset_pkg::VALUE_W;
  localparam int KW = sset_pkg::KEY_W;
  localparam int EW = sset_pkg::ENTRY_W;
  localparam int PAD_W = sset_pkg::OUT_W - sset_pkg::STATUS_W - VW - sset_pkg::COUNT_OUT_W;

  // entry memory: {row, col, value}
  logic [EW-1:0] mem [CAPACITY];
  logic [EW-1:0] rd_data;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [EW-1:0] mem_wdata;

  sset_pkg::state_t state, state_next;

  // bounds registers
  logic [IW-1:0] row_count;
  logic [IW-1:0] col_count;

  // item held during work
  logic          action_q;
  logic [IW-1:0] row_q;
  logic [IW-1:0] col_q;
  logic [VW-1:0] value_q;

  logic [CW-1:0] count;
  logic [CW-1:0] idx;
  logic [CW-1:0] pos;
  logic          hit;
  sset_pkg::status_t status_q;
  logic [VW-1:0] rv_q;

  // result register
  sset_pkg::status_t out_status;
  logic [VW-1:0]     out_value;
  logic [sset_pkg::COUNT_OUT_W-1:0] out_count;

  // shared key comparator
  logic [KW-1:0] key_in;
  logic [KW-1:0] ent_key;
  logic          ent_lt;
  logic          ent_eq;
  logic [CW-1:0] idx_inc;
  logic [CW-1:0] idx_dec;
  logic          oob;
  logic          full;
  logic          val_zero;
  logic          fin_go;

  assign key_in   = {row_q, col_q};
  assign ent_key  = rd_data[EW-1:VW];
  assign ent_lt   = ent_key < key_in;
  assign ent_eq   = ent_key == key_in;
  assign idx_inc  = idx + CW'(1);
  assign idx_dec  = idx - CW'(1);
  assign oob      = (row_q >= row_count) || (col_q >= col_count);
  assign full     = count == CW'(CAPACITY);
  assign val_zero = value_q == '0;
  assign fin_go   = !m_tvalid || m_tready;

  assign cfg_ready = 1'b1;
  assign m_tdata   = {{PAD_W{1'b0}}, out_count, out_value, out_status};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= mem[mem_raddr];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      sset_pkg::S_IDLE: begin
        if (s_tvalid) state_next = sset_pkg::S_CHECK;
      end
      sset_pkg::S_CHECK: begin
        state_next = oob ? sset_pkg::S_FIN : sset_pkg::S_SCAN_RD;
      end
      sset_pkg::S_SCAN_RD: begin
        state_next = (idx == count) ? sset_pkg::S_DECIDE : sset_pkg::S_SCAN_CMP;
      end
      sset_pkg::S_SCAN_CMP: begin
        state_next = ent_lt ? sset_pkg::S_SCAN_RD : sset_pkg::S_DECIDE;
      end
      sset_pkg::S_DECIDE: begin
        if (action_q || (hit && !val_zero) || (!hit && val_zero) || (!hit && full)) begin
          state_next = sset_pkg::S_FIN;
        end else if (hit) begin
          state_next = sset_pkg::S_DEL_RD;
        end else begin
          state_next = sset_pkg::S_INS_RD;
        end
      end
      sset_pkg::S_DEL_RD: begin
        state_next = (idx_inc < count) ? sset_pkg::S_DEL_WR : sset_pkg::S_FIN;
      end
      sset_pkg::S_DEL_WR: state_next = sset_pkg::S_DEL_RD;
      sset_pkg::S_INS_RD: begin
        state_next = (idx > pos) ? sset_pkg::S_INS_WR : sset_pkg::S_FIN;
      end
      sset_pkg::S_INS_WR: state_next = sset_pkg::S_INS_RD;
      sset_pkg::S_FIN: begin
        if (fin_go) state_next = sset_pkg::S_IDLE;
      end
      default: state_next = sset_pkg::S_IDLE;
    endcase
  end

  // memory control and input handshake
  always_comb begin
    s_tready  = 1'b0;
    mem_re    = 1'b0;
    mem_raddr = idx[AW-1:0];
    mem_we    = 1'b0;
    mem_waddr = idx[AW-1:0];
    mem_wdata = rd_data;
    case (state)
      sset_pkg::S_IDLE: s_tready = 1'b1;
      sset_pkg::S_SCAN_RD: begin
        mem_re = idx != count;
      end
      sset_pkg::S_DECIDE: begin
        // replace in place
        if (!action_q && hit && !val_zero) begin
          mem_we    = 1'b1;
          mem_waddr = pos[AW-1:0];
          mem_wdata = {row_q, col_q, value_q};
        end
      end
      sset_pkg::S_DEL_RD: begin
        mem_re    = idx_inc < count;
        mem_raddr = idx_inc[AW-1:0];
      end
      sset_pkg::S_DEL_WR: mem_we = 1'b1;
      sset_pkg::S_INS_RD: begin
        if (idx > pos) begin
          mem_re    = 1'b1;
          mem_raddr = idx_dec[AW-1:0];
        end else begin
          mem_we    = 1'b1;
          mem_waddr = pos[AW-1:0];
          mem_wdata = {row_q, col_q, value_q};
        end
      end
      sset_pkg::S_INS_WR: mem_we = 1'b1;
      default: ;
    endcase
  end

  // control and count
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= sset_pkg::S_IDLE;
      count     <= '0;
      m_tvalid  <= 1'b0;
      row_count <= sset_pkg::DIM_RESET;
      col_count <= sset_pkg::DIM_RESET;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          sset_pkg::REG_ROW_COUNT: row_count <= cfg_data;
          sset_pkg::REG_COL_COUNT: col_count <= cfg_data;
          default: ;
        endcase
      end
      if (state == sset_pkg::S_DEL_RD && !(idx_inc < count)) begin
        count <= count - CW'(1);
      end
      if (state == sset_pkg::S_INS_RD && !(idx > pos)) begin
        count <= count + CW'(1);
      end
      if (state == sset_pkg::S_FIN && fin_go) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // item datapath
  always_ff @(posedge clk) begin
    case (state)
      sset_pkg::S_IDLE: begin
        action_q <= s_tdata[0];
        row_q    <= s_tdata[IW:1];
        col_q    <= s_tdata[2*IW:IW+1];
        value_q  <= s_tdata[2*IW+VW:2*IW+1];
        idx      <= '0;
        rv_q     <= '0;
      end
      sset_pkg::S_CHECK: status_q <= sset_pkg::ST_OUT_OF_BOUNDS;
      sset_pkg::S_SCAN_RD: begin
        if (idx == count) begin
          pos <= idx;
          hit <= 1'b0;
        end
      end
      sset_pkg::S_SCAN_CMP: begin
        if (ent_lt) begin
          idx <= idx_inc;
        end else begin
          pos  <= idx;
          hit  <= ent_eq;
          if (ent_eq && action_q) rv_q <= rd_data[VW-1:0];
        end
      end
      sset_pkg::S_DECIDE: begin
        if (action_q) begin
          status_q <= sset_pkg::ST_READ;
        end else if (hit && !val_zero) begin
          status_q <= sset_pkg::ST_REPLACED;
        end else if (hit) begin
          status_q <= sset_pkg::ST_REMOVED;
        end else if (val_zero) begin
          status_q <= sset_pkg::ST_ZERO_NOP;
        end else if (full) begin
          status_q <= sset_pkg::ST_FULL;
        end else begin
          status_q <= sset_pkg::ST_INSERTED;
          idx      <= count;
        end
      end
      sset_pkg::S_DEL_WR: idx <= idx_inc;
      sset_pkg::S_INS_WR: idx <= idx_dec;
      sset_pkg::S_FIN: begin
        if (fin_go) begin
          out_status <= status_q;
          out_value  <= rv_q;
          out_count  <= sset_pkg::COUNT_OUT_W'(count);
        end
      end
      default: ;
    endcase
  end

  // count stays within the table
  `SSET_ASSERT(a_count_le_cap, count <= CW'(CAPACITY))
  // writes never land more than one place past the end of the filled region
  `SSET_ASSERT(a_write_in_range, !mem_we || (CW'(mem_waddr) <= count))
  // count only moves when a remove or insert finishes
  `SSET_ASSERT_NEXT(a_count_hold, state != sset_pkg::S_DEL_RD && state != sset_pkg::S_INS_RD, $stable(count))
  // scan result never points past the stored entries
  `SSET_ASSERT(a_pos_bound, state != sset_pkg::S_DECIDE || pos <= count)
  // an accepted item always starts with the bounds check
  `SSET_ASSERT_NEXT(a_accept_check, s_tvalid && s_tready, state == sset_pkg::S_CHECK)

endmodule

`default_nettype wire
